/* hw/rtl/ecu_pkg.sv */
// Shared types, constants and lookup tables for the easing curve unit.
// Used by the top level, the elastic path and the port checker.
// No dependencies.
package ecu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = FRAC_BITS + 2;
   localparam int TW        = FRAC_BITS + 1;
   localparam int NSTG      = 7;

   localparam logic [TW-1:0] ONE_Q  = TW'(1 << FRAC_BITS);
   localparam logic [TW-1:0] HALF_Q = TW'(1 << (FRAC_BITS - 1));

   localparam logic [63:0] BACK_C1_Q32 = 64'd7308230452;
   localparam logic [TW-1:0] BACK_C1_Q =
      TW'((BACK_C1_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
   localparam logic [TW:0] BACK_C3_Q = {1'b0, BACK_C1_Q} + {1'b0, ONE_Q};

   typedef enum logic [2:0] {
      MODE_LINEAR,
      MODE_QUAD_IN,
      MODE_QUAD_OUT,
      MODE_QUAD_INOUT,
      MODE_ELASTIC_IN,
      MODE_BOUNCE_OUT,
      MODE_BACK_OUT,
      MODE_CUBIC_INOUT
   } mode_type;

   function automatic logic [17:0] exp2_tab(input logic [4:0] idx);
      logic [17:0] v;
      case (idx)
         5'd0:  v = 18'd65536;
         5'd1:  v = 18'd68438;
         5'd2:  v = 18'd71468;
         5'd3:  v = 18'd74632;
         5'd4:  v = 18'd77936;
         5'd5:  v = 18'd81384;
         5'd6:  v = 18'd84990;
         5'd7:  v = 18'd88752;
         5'd8:  v = 18'd92682;
         5'd9:  v = 18'd96785;
         5'd10: v = 18'd101070;
         5'd11: v = 18'd105545;
         5'd12: v = 18'd110218;
         5'd13: v = 18'd115098;
         5'd14: v = 18'd120194;
         5'd15: v = 18'd125515;
         default: v = 18'd131072;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] sine_tab(input logic [4:0] idx);
      logic [16:0] v;
      case (idx)
         5'd0:  v = 17'd0;
         5'd1:  v = 17'd6424;
         5'd2:  v = 17'd12785;
         5'd3:  v = 17'd19024;
         5'd4:  v = 17'd25080;
         5'd5:  v = 17'd30893;
         5'd6:  v = 17'd36410;
         5'd7:  v = 17'd41576;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd50660;
         5'd10: v = 17'd54491;
         5'd11: v = 17'd57798;
         5'd12: v = 17'd60547;
         5'd13: v = 17'd62714;
         5'd14: v = 17'd64277;
         5'd15: v = 17'd65220;
         default: v = 17'd65536;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/ecu_elastic.sv */
// Elastic-in curve path of the easing curve unit: table-based 2^x and sine,
// six register stages that advance with the top level's stage enables.
// Depends on ecu_pkg.
module ecu_elastic import ecu_pkg::*; (
   input  logic                        clock,
   input  logic [NSTG-2:0]             en,
   input  logic [TW-1:0]               t_c,
   output logic signed [WORD_BITS-1:0] el_res
);

   localparam logic [22:0] RECIP3 = 23'd5592406;

   logic [TW-1:0] om_c;
   logic [19:0]   e_c;
   logic [19:0]   num_c;
   logic [TW-1:0] g_c;
   logic [17:0]   gbase_c;
   logic [17:0]   gnext_c;

   logic          s1_zero_ff, s1_one_ff;
   logic [3:0]    s1_ip_ff;
   logic [17:0]   s1_base_ff;
   logic [12:0]   s1_diff_ff;
   logic [11:0]   s1_rem_ff;
   logic [21:0]   s1_n_ff;

   logic          s2_zero_ff, s2_one_ff;
   logic [3:0]    s2_ip_ff;
   logic [17:0]   s2_base_ff;
   logic [24:0]   s2_vmul_ff;
   logic [44:0]   s2_phm_ff;

   logic [17:0]   val_c;
   logic [17:0]   ph_c;
   logic [TW-1:0] ws_c;
   logic [16:0]   sbase_c;
   logic [16:0]   snext_c;

   logic          s3_zero_ff, s3_one_ff, s3_neg_ff;
   logic [3:0]    s3_ip_ff;
   logic [17:0]   s3_val_ff;
   logic [16:0]   s3_sbase_ff;
   logic [12:0]   s3_sdiff_ff;
   logic [11:0]   s3_srem_ff;

   logic          s4_zero_ff, s4_one_ff, s4_neg_ff;
   logic [3:0]    s4_ip_ff;
   logic [17:0]   s4_val_ff;
   logic [16:0]   s4_sbase_ff;
   logic [24:0]   s4_smul_ff;

   logic [25:0]   ssum_c;
   logic          s5_zero_ff, s5_one_ff, s5_neg_ff;
   logic [3:0]    s5_ip_ff;
   logic [17:0]   s5_val_ff;
   logic [16:0]   s5_s_ff;

   logic          s6_zero_ff, s6_one_ff, s6_neg_ff;
   logic [3:0]    s6_ip_ff;
   logic [34:0]   s6_prod_ff;

   logic [35:0]   rsum_c;
   logic [35:0]   rshift_c;
   logic [TW-1:0] mag_c;

   always_comb begin
      om_c    = ONE_Q - t_c;
      e_c     = (20'(om_c) << 3) + (20'(om_c) << 1);
      g_c     = ONE_Q - {1'b0, e_c[FRAC_BITS-1:0]};
      gbase_c = exp2_tab(g_c[16:12]);
      gnext_c = exp2_tab(5'(g_c[16:12] + 5'd1));
      num_c   = e_c + 20'd49152;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_zero_ff <= (t_c == '0);
         s1_one_ff  <= (t_c == ONE_Q);
         s1_ip_ff   <= e_c[19:16];
         s1_base_ff <= gbase_c;
         s1_diff_ff <= 13'(gnext_c - gbase_c);
         s1_rem_ff  <= g_c[11:0];
         s1_n_ff    <= {num_c, 2'b01};
      end
      if (en[1]) begin
         s2_zero_ff <= s1_zero_ff;
         s2_one_ff  <= s1_one_ff;
         s2_ip_ff   <= s1_ip_ff;
         s2_base_ff <= s1_base_ff;
         s2_vmul_ff <= 25'(s1_diff_ff) * 25'(s1_rem_ff);
         s2_phm_ff  <= 45'(s1_n_ff) * 45'(RECIP3);
      end
   end

   always_comb begin
      val_c   = s2_base_ff + 18'((26'(s2_vmul_ff) + 26'd2048) >> 12);
      ph_c    = s2_phm_ff[41:24];
      ws_c    = ph_c[16] ? (ONE_Q - {1'b0, ph_c[15:0]}) : {1'b0, ph_c[15:0]};
      sbase_c = sine_tab(ws_c[16:12]);
      snext_c = sine_tab(5'(ws_c[16:12] + 5'd1));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_zero_ff  <= s2_zero_ff;
         s3_one_ff   <= s2_one_ff;
         s3_neg_ff   <= ph_c[17];
         s3_ip_ff    <= s2_ip_ff;
         s3_val_ff   <= val_c;
         s3_sbase_ff <= sbase_c;
         s3_sdiff_ff <= 13'(snext_c - sbase_c);
         s3_srem_ff  <= ws_c[11:0];
      end
      if (en[3]) begin
         s4_zero_ff  <= s3_zero_ff;
         s4_one_ff   <= s3_one_ff;
         s4_neg_ff   <= s3_neg_ff;
         s4_ip_ff    <= s3_ip_ff;
         s4_val_ff   <= s3_val_ff;
         s4_sbase_ff <= s3_sbase_ff;
         s4_smul_ff  <= 25'(s3_sdiff_ff) * 25'(s3_srem_ff);
      end
   end

   assign ssum_c = 26'(s4_sbase_ff) + ((26'(s4_smul_ff) + 26'd2048) >> 12);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_zero_ff <= s4_zero_ff;
         s5_one_ff  <= s4_one_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_ip_ff   <= s4_ip_ff;
         s5_val_ff  <= s4_val_ff;
         s5_s_ff    <= ssum_c[16:0];
      end
      if (en[5]) begin
         s6_zero_ff <= s5_zero_ff;
         s6_one_ff  <= s5_one_ff;
         s6_neg_ff  <= s5_neg_ff;
         s6_ip_ff   <= s5_ip_ff;
         s6_prod_ff <= 35'(s5_val_ff) * 35'(s5_s_ff);
      end
   end

   always_comb begin
      rsum_c   = 36'(s6_prod_ff) + (36'd1 << (FRAC_BITS + 32'(s6_ip_ff)));
      rshift_c = rsum_c >> (FRAC_BITS + 1 + 32'(s6_ip_ff));
      mag_c    = rshift_c[TW-1:0];
      if (s6_zero_ff) begin
         el_res = '0;
      end else if (s6_one_ff) begin
         el_res = $signed({1'b0, ONE_Q});
      end else if (s6_neg_ff) begin
         el_res = -$signed({1'b0, mag_c});
      end else begin
         el_res = $signed({1'b0, mag_c});
      end
   end

endmodule

/* hw/rtl/easing_curve_unit.sv */
// Easing curve unit: takes a progress value and a curve mode and returns the
// eased value in signed Q2.16. Depends on ecu_pkg and ecu_elastic.
//
// The unit is a seven-stage pipeline that accepts one item per clock cycle while its
// output is not stalled; each item passes through stages s1 to s6 and the output
// register, and the depth is set by the back-out curve's three chained multiplies and
// the elastic path's table lookups, each of which takes its own register stage.
// Progress is clamped to 0..1, results are rounded to nearest and saturated, and
// every stage holds its item under back-pressure, so bubbles in the pipe are still
// filled while a finished result waits at the output.
module easing_curve_unit import ecu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // progress [17:0], easing_mode [20:18], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // eased [17:0], zero pad
);

   localparam int BW = 21;
   localparam logic [BW-1:0] ONE_B = BW'(1) << FRAC_BITS;

   logic [NSTG-1:0] en;
   logic [NSTG-1:0] v_ff, v_in;

   logic [WORD_BITS-1:0] raw_c;
   mode_type             mode_c;
   logic [TW-1:0]        t_c, u_c, uu_c, x_c, y_c, y2_c;
   logic                 lo_c;
   logic [BW-1:0]        t11_c, d22_c, bk_c;
   logic signed [BW:0]   bd_c;
   logic [18:0]          bad_c;
   logic [TW-1:0]        bbase_c;
   logic signed [WORD_BITS-1:0] el_res;

   mode_type      s1_mode_ff;
   logic          s1_lo_ff;
   logic [TW-1:0] s1_t_ff, s1_x_ff, s1_y_ff, s1_y2_ff, s1_bbase_ff;
   logic [18:0]   s1_bad_ff;

   mode_type      s2_mode_ff;
   logic          s2_lo_ff;
   logic [TW-1:0] s2_t_ff, s2_y2_ff, s2_bbase_ff;
   logic [33:0]   s2_p1_ff;
   logic [37:0]   s2_pb_ff;

   logic [34:0]   p1sum_c;
   logic [TW-1:0] p1r_c, p1h_c;
   logic [TW:0]   p1inc_c;
   logic [38:0]   pbsum_c;
   logic [TW-1:0] bres_c, resa_c;

   mode_type      s3_mode_ff;
   logic          s3_lo_ff;
   logic [TW-1:0] s3_y2_ff, s3_p1r_ff, s3_res_ff;

   mode_type      s4_mode_ff;
   logic          s4_lo_ff;
   logic [TW-1:0] s4_res_ff;
   logic [33:0]   s4_p2a_ff, s4_p2b_ff;

   logic [34:0]   p2asum_c, p2bsum_c;
   logic [TW-1:0] q2_c;
   logic [TW:0]   q2inc_c;
   logic [TW-1:0] resb_c;

   mode_type      s5_mode_ff;
   logic [TW-1:0] s5_res_ff, s5_q2_ff, s5_cu2_ff;

   mode_type      s6_mode_ff;
   logic [TW-1:0] s6_res_ff, s6_cu2_ff;
   logic [34:0]   s6_p3_ff;

   logic [35:0]          p3sum_c;
   logic [19:0]          p3r_c;
   logic signed [19:0]   fin_c;
   logic [WORD_BITS-1:0] sat_c;
   logic [WORD_BITS-1:0] eased_ff;

   // Each stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign v_in       = (({v_ff[NSTG-2:0], req_tvalid}) & en) | (v_ff & ~en);
   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NSTG-1];
   assign rsp_tdata  = {(24 - WORD_BITS)'(0), eased_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      raw_c  = req_tdata[WORD_BITS-1:0];
      mode_c = mode_type'(req_tdata[WORD_BITS+2:WORD_BITS]);
      if (raw_c[WORD_BITS-1]) begin
         t_c = '0;
      end else if (raw_c[TW-1:0] > ONE_Q) begin
         t_c = ONE_Q;
      end else begin
         t_c = raw_c[TW-1:0];
      end
      u_c  = ONE_Q - t_c;
      uu_c = {u_c[TW-2:0], 1'b0};
      lo_c = (t_c < HALF_Q);
      x_c  = '0;
      y_c  = '0;
      y2_c = '0;
      case (mode_c)
         MODE_QUAD_IN: begin
            x_c = t_c;
            y_c = t_c;
         end
         MODE_QUAD_OUT: begin
            x_c = u_c;
            y_c = u_c;
         end
         MODE_BACK_OUT: begin
            x_c  = u_c;
            y_c  = u_c;
            y2_c = u_c;
         end
         MODE_QUAD_INOUT: begin
            x_c = lo_c ? {t_c[TW-2:0], 1'b0} : uu_c;
            y_c = lo_c ? t_c : uu_c;
         end
         MODE_CUBIC_INOUT: begin
            x_c  = lo_c ? t_c : uu_c;
            y_c  = lo_c ? t_c : uu_c;
            y2_c = lo_c ? {t_c[TW-3:0], 2'b00} : uu_c;
         end
         default: begin
            x_c = '0;
         end
      endcase

      // The bounce pieces are parabolas in D = 22t - k, so D*D/64 is exact.
      t11_c = (BW'(t_c) << 3) + (BW'(t_c) << 1) + BW'(t_c);
      d22_c = t11_c << 1;
      if (t11_c < (ONE_B << 2)) begin
         bk_c    = '0;
         bbase_c = '0;
      end else if (t11_c < (ONE_B << 3)) begin
         bk_c    = ONE_B * BW'(12);
         bbase_c = TW'((32'(ONE_Q) * 3) >> 2);
      end else if (t11_c < (ONE_B * BW'(10))) begin
         bk_c    = ONE_B * BW'(18);
         bbase_c = TW'((32'(ONE_Q) * 15) >> 4);
      end else begin
         bk_c    = ONE_B * BW'(21);
         bbase_c = TW'((32'(ONE_Q) * 63) >> 6);
      end
      bd_c  = $signed({1'b0, d22_c}) - $signed({1'b0, bk_c});
      bad_c = bd_c[BW] ? 19'(-bd_c) : bd_c[18:0];
   end

   ecu_elastic u_elastic (
      .clock  (clock),
      .en     (en[NSTG-2:0]),
      .t_c    (t_c),
      .el_res (el_res)
   );

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_mode_ff  <= mode_c;
         s1_lo_ff    <= lo_c;
         s1_t_ff     <= t_c;
         s1_x_ff     <= x_c;
         s1_y_ff     <= y_c;
         s1_y2_ff    <= y2_c;
         s1_bad_ff   <= bad_c;
         s1_bbase_ff <= bbase_c;
      end
      if (en[1]) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_lo_ff    <= s1_lo_ff;
         s2_t_ff     <= s1_t_ff;
         s2_y2_ff    <= s1_y2_ff;
         s2_bbase_ff <= s1_bbase_ff;
         s2_p1_ff    <= 34'(s1_x_ff) * 34'(s1_y_ff);
         s2_pb_ff    <= 38'(s1_bad_ff) * 38'(s1_bad_ff);
      end
   end

   always_comb begin
      p1sum_c = 35'(s2_p1_ff) + 35'(HALF_Q);
      p1r_c   = p1sum_c[FRAC_BITS+TW-1:FRAC_BITS];
      p1inc_c = {1'b0, p1r_c} + (TW+1)'(1);
      p1h_c   = p1inc_c[TW:1];
      pbsum_c = 39'(s2_pb_ff) + (39'd32 << FRAC_BITS);
      bres_c  = TW'(pbsum_c >> (FRAC_BITS + 6)) + s2_bbase_ff;
      case (s2_mode_ff)
         MODE_QUAD_IN:    resa_c = p1r_c;
         MODE_QUAD_OUT:   resa_c = ONE_Q - p1r_c;
         MODE_QUAD_INOUT: resa_c = s2_lo_ff ? p1r_c : (ONE_Q - p1h_c);
         MODE_BOUNCE_OUT: resa_c = bres_c;
         default:         resa_c = s2_t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_mode_ff <= s2_mode_ff;
         s3_lo_ff   <= s2_lo_ff;
         s3_y2_ff   <= s2_y2_ff;
         s3_p1r_ff  <= p1r_c;
         s3_res_ff  <= resa_c;
      end
      if (en[3]) begin
         s4_mode_ff <= s3_mode_ff;
         s4_lo_ff   <= s3_lo_ff;
         s4_res_ff  <= s3_res_ff;
         s4_p2a_ff  <= 34'(s3_p1r_ff) * 34'(s3_y2_ff);
         s4_p2b_ff  <= 34'(s3_p1r_ff) * 34'(BACK_C1_Q);
      end
   end

   always_comb begin
      p2asum_c = 35'(s4_p2a_ff) + 35'(HALF_Q);
      p2bsum_c = 35'(s4_p2b_ff) + 35'(HALF_Q);
      q2_c     = p2asum_c[FRAC_BITS+TW-1:FRAC_BITS];
      q2inc_c  = {1'b0, q2_c} + (TW+1)'(1);
      if (s4_mode_ff == MODE_CUBIC_INOUT) begin
         resb_c = s4_lo_ff ? q2_c : (ONE_Q - q2inc_c[TW:1]);
      end else begin
         resb_c = s4_res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_mode_ff <= s4_mode_ff;
         s5_res_ff  <= resb_c;
         s5_q2_ff   <= q2_c;
         s5_cu2_ff  <= p2bsum_c[FRAC_BITS+TW-1:FRAC_BITS];
      end
      if (en[5]) begin
         s6_mode_ff <= s5_mode_ff;
         s6_res_ff  <= s5_res_ff;
         s6_cu2_ff  <= s5_cu2_ff;
         s6_p3_ff   <= 35'(BACK_C3_Q) * 35'(s5_q2_ff);
      end
   end

   always_comb begin
      p3sum_c = 36'(s6_p3_ff) + 36'(HALF_Q);
      p3r_c   = 20'(p3sum_c >> FRAC_BITS);
      case (s6_mode_ff)
         MODE_BACK_OUT:   fin_c = $signed(20'(ONE_Q) + 20'(s6_cu2_ff) - p3r_c);
         MODE_ELASTIC_IN: fin_c = 20'(el_res);
         default:         fin_c = $signed(20'(s6_res_ff));
      endcase
      if (fin_c > $signed(20'((1 << (WORD_BITS - 1)) - 1))) begin
         sat_c = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (fin_c < -$signed(20'(1 << (WORD_BITS - 1)))) begin
         sat_c = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         sat_c = fin_c[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         eased_ff <= sat_c;
      end
   end

endmodule

/* hw/rtl/ecu_checker.sv */
// Port-level checker for the easing curve unit and its bind to the top level.
// Depends on ecu_pkg.
module ecu_port_checker import ecu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic signed [WORD_BITS-1:0] eased_v;
   assign eased_v = $signed(rsp_tdata[WORD_BITS-1:0]);

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_full_only_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused while the pipeline could move");

   // The elastic curve dips to about -0.37 and back out peaks near 1.1.
   a_eased_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (eased_v >= -$signed(WORD_BITS'(ONE_Q >> 1)))
                  && (eased_v <= $signed(WORD_BITS'(ONE_Q + (ONE_Q >> 1))))
                  && (rsp_tdata[23:WORD_BITS] == '0))
      else $error("eased value outside the curves' range");

endmodule

bind easing_curve_unit ecu_port_checker u_ecu_checker (.*);

/* tb/ecu_checker.sv */
// Checker for the easing curve unit: watches both streams, predicts each eased value
// from the accepted item and compares it with the returned one. Depends on ecu_pkg.
`timescale 1ns / 1ps
module ecu_checker import ecu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count,
   output int          result_count
);

   localparam longint ONE = 64'd1 << FRAC_BITS;

   logic [17:0] eased_queue[$];

   function automatic longint rmul(longint a, longint b);
      return (a * b + ONE / 2) >>> FRAC_BITS;
   endfunction

   function automatic longint qsin(longint w);
      longint i, r, a, b;
      i = w >>> 12;
      r = w & 4095;
      if (i >= 16) return 65536;
      a = sine_tab(i[4:0]);
      b = sine_tab(i[4:0] + 5'd1);
      return a + (((b - a) * r + 2048) >>> 12);
   endfunction

   function automatic longint elastic(longint t);
      longint e, ip, g, i, r, v, a, b, ph, quad, w, s, p, sh;
      if (t == 0) return 0;
      if (t >= ONE) return ONE;
      e = 10 * (ONE - t);
      ip = (e >>> FRAC_BITS) & 15;
      g = ONE - (e & (ONE - 1));
      i = g >>> (FRAC_BITS - 4);
      r = g & ((64'd1 << (FRAC_BITS - 4)) - 1);
      if (i >= 16) v = 131072;
      else begin
         a = exp2_tab(i[4:0]);
         b = exp2_tab(i[4:0] + 5'd1);
         v = a + (((b - a) * r + (64'd1 << (FRAC_BITS - 5))) >>> (FRAC_BITS - 4));
      end
      ph = (((e + 3 * ONE / 4) << 18) + 3 * ONE / 2) / (3 * ONE);
      ph = ph & ((64'd1 << 18) - 1);
      quad = ph >>> 16;
      w = ph & 16'hFFFF;
      s = quad[0] ? qsin(65536 - w) : qsin(w);
      sh = 33 + ip - FRAC_BITS;
      p = (v * s + (64'd1 << (sh - 1))) >>> sh;
      return (quad >= 2) ? -p : p;
   endfunction

   function automatic longint bounce(longint t);
      longint d, base;
      if (11 * t < 4 * ONE) begin
         d = 22 * t; base = 0;
      end else if (11 * t < 8 * ONE) begin
         d = 22 * t - 12 * ONE; base = 3 * ONE / 4;
      end else if (11 * t < 10 * ONE) begin
         d = 22 * t - 18 * ONE; base = 15 * ONE / 16;
      end else begin
         d = 22 * t - 21 * ONE; base = 63 * ONE / 64;
      end
      if (d < 0) d = -d;
      return ((d * d + (64'd32 << FRAC_BITS)) >>> (FRAC_BITS + 6)) + base;
   endfunction

   function automatic logic [17:0] predict_eased(logic [17:0] prog, mode_type mode);
      longint t, u, r, c1;
      if (prog[17]) t = 0;
      else if (prog > ONE) t = ONE;
      else t = prog;
      u = ONE - t;
      case (mode)
         MODE_QUAD_IN: r = rmul(t, t);
         MODE_QUAD_OUT: r = ONE - rmul(u, u);
         MODE_QUAD_INOUT: begin
            if (t < ONE / 2) r = rmul(2 * t, t);
            else r = ONE - ((rmul(2 * u, 2 * u) + 1) >>> 1);
         end
         MODE_ELASTIC_IN: r = elastic(t);
         MODE_BOUNCE_OUT: r = bounce(t);
         MODE_BACK_OUT: begin
            c1 = (64'd7308230452 + (64'd1 << (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
            r = ONE + rmul(c1, rmul(u, u)) - rmul(c1 + ONE, rmul(rmul(u, u), u));
         end
         MODE_CUBIC_INOUT: begin
            if (t < ONE / 2) r = rmul(rmul(t, t), 4 * t);
            else r = ONE - ((rmul(rmul(2 * u, 2 * u), 2 * u) + 1) >>> 1);
         end
         default: r = t;
      endcase
      if (r > 131071) r = 131071;
      if (r < -131072) r = -131072;
      return r[17:0];
   endfunction

   assign pending_count = eased_queue.size();

   always @(posedge clock) begin
      if (reset) begin
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            eased_queue.push_back(predict_eased(req_tdata[17:0], mode_type'(req_tdata[20:18])));
         end
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (eased_queue.size() == 0) begin
               $error("unexpected result: eased actual %h", rsp_tdata[17:0]);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_tdata[17:0] !== eased_queue[0]) begin
                  $error("eased: expected %h actual %h", eased_queue[0], rsp_tdata[17:0]);
                  fail_count <= fail_count + 1;
               end
               void'(eased_queue.pop_front());
            end
         end
      end
   end

endmodule

/* tb/tb_top.sv */
// Testbench top for the easing curve unit: drives progress and mode items with random
// idling and back-pressure and gives the verdict. Depends on ecu_pkg, ecu_checker and easing_curve_unit.
`timescale 1ns / 1ps
module tb_top;
   import ecu_pkg::*;

   localparam int N_RANDOM = 1300;
   localparam int WATCHDOG = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   int          fail_count, pending_count, result_count;
   int          idle_cycles;
   int          item_count;
   bit          calm;
   bit          long_hold;
   bit          sending_done;

   always #4 clock = ~clock;

   easing_curve_unit dut (.*);

   ecu_checker checker_inst (.*);

   task automatic send_item(logic [17:0] prog, mode_type mode);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {3'b000, 3'(mode), prog};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      item_count++;
      @(negedge clock);
   endtask

   function automatic logic [17:0] random_progress();
      case ($urandom_range(0, 5))
         0: return 18'($urandom);
         1: return 18'($urandom_range(65530, 65542));
         2: return 18'($urandom_range(0, 8));
         default: return 18'($urandom_range(0, 65536));
      endcase
   endfunction

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (long_hold) rsp_tready <= 1'b0;
      else if (calm) rsp_tready <= 1'b1;
      else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
         rsp_tready <= 1'b1;
      end else rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("FAIL easing_curve_unit");
         $finish;
      end
   end

   initial begin
      calm = 1'b0;
      long_hold = 1'b0;
      sending_done = 1'b0;
      item_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int m = 0; m < 8; m++) begin
         send_item(18'h00000, mode_type'(m));
         send_item(18'h10000, mode_type'(m));
         send_item(18'h08000, mode_type'(m));
      end
      send_item(18'h20000, MODE_BACK_OUT);
      send_item(18'h1FFFF, MODE_ELASTIC_IN);
      send_item(18'h3FFFF, MODE_BOUNCE_OUT);
      send_item(18'h00001, MODE_ELASTIC_IN);
      send_item(18'h0FFFF, MODE_ELASTIC_IN);
      req_tvalid <= 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
      fork
         begin
            long_hold = 1'b1;
            repeat (60) @(negedge clock);
            long_hold = 1'b0;
         end
         for (int i = 0; i < 40; i++) send_item(random_progress(), mode_type'($urandom_range(0, 7)));
      join
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i > N_RANDOM - 200) calm = 1'b1;
         send_item(random_progress(), mode_type'($urandom_range(0, 7)));
      end
      req_tvalid <= 1'b0;
      sending_done = 1'b1;
      wait (pending_count == 0);
      repeat (20) @(posedge clock);
      $display("Sent %0d items over all eight curves, clamped and edge progress values,",
               item_count);
      $display("and checked %0d results under random idling and a long output stall.",
               result_count);
      if (fail_count == 0) $display("PASS easing_curve_unit");
      else $display("FAIL easing_curve_unit");
      $finish;
   end

endmodule
